@@ sv/rsa_me_pkg.sv @@
// rsa_me_pkg: shared widths, codes, reset values and the modular add step
// for the modular exponentiation block; no dependencies
`timescale 1ns / 1ps

package rsa_me_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CFG_IDX_W  = 2;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_MODULUS          = 2'd0;
    localparam cfg_idx_t CFG_PUBLIC_EXPONENT  = 2'd1;
    localparam cfg_idx_t CFG_PRIVATE_EXPONENT = 2'd2;

    // command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // register reset values
    localparam word_t MODULUS_RST          = word_t'(3233);
    localparam word_t PUBLIC_EXPONENT_RST  = word_t'(17);
    localparam word_t PRIVATE_EXPONENT_RST = word_t'(413);

    // status of the shared multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

    // (x + y) mod m for x, y below m
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        logic [DATA_WIDTH:0] sum;
        logic [DATA_WIDTH:0] diff;
        sum  = {1'b0, x} + {1'b0, y};
        diff = sum - {1'b0, m};
        if (sum >= {1'b0, m})
        begin
            return diff[DATA_WIDTH-1:0];
        end
        return sum[DATA_WIDTH-1:0];
    endfunction

endpackage

@@ sv/rsa_me_mulmod.sv @@
// rsa_me_mulmod: iterative shift-and-add modular multiplier, one bit of b
// per cycle; depends on rsa_me_pkg
`timescale 1ns / 1ps

module rsa_me_mulmod (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  rsa_me_pkg::word_t      a,
    input  rsa_me_pkg::word_t      b,
    input  rsa_me_pkg::word_t      m,
    output rsa_me_pkg::word_t      product,
    output rsa_me_pkg::mm_status_t status
);

    rsa_me_pkg::word_t a_reg, a_next;
    rsa_me_pkg::word_t b_reg, b_next;
    rsa_me_pkg::word_t m_reg, m_next;
    rsa_me_pkg::word_t acc_reg, acc_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            m_next    = m;
            acc_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = rsa_me_pkg::add_mod(acc_reg, a_reg, m_reg);
                end
                a_next = rsa_me_pkg::add_mod(a_reg, a_reg, m_reg);
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ sv/rsa_modular_exponentiation_top.sv @@
// rsa_modular_exponentiation_top: sequencer, configuration registers and
// output register; depends on rsa_me_pkg and rsa_me_mulmod
`timescale 1ns / 1ps

// usage
//   input channel (in_valid/in_ready): command selects the exponent, 0 for
//   the public exponent, 1 for the private exponent; operand_value is the
//   message or ciphertext. result_value = operand_value^exponent mod modulus
//   comes back on the output channel (out_valid/out_ready), one result per
//   transaction, in order.
//   config channel (cfg_valid/cfg_ready): cfg_index 0 modulus, 1 public
//   exponent, 2 private exponent; index 3 is ignored. always ready; write
//   only while the block is idle.
//   timing: the operand is first reduced mod modulus, then the exponent is
//   scanned lsb first with a multiply per set bit and a square per bit.
//   every multiplication runs on one shared shift-and-add unit, one
//   multiplier bit per cycle. short exponents finish sooner; one item is
//   worked at a time and in_ready is low meanwhile.
//   the finished result sits in an output register, so a new transaction is
//   taken while it waits; if the receiver still stalls when the next result
//   is ready, the sequencer holds it until the register frees up.
//   reset: modulus 3233, exponents 17 and 413; no result is pending.
module rsa_modular_exponentiation_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  rsa_me_pkg::word_t        operand_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rsa_me_pkg::word_t        result_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  rsa_me_pkg::cfg_idx_t     cfg_index,
    input  rsa_me_pkg::word_t        cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL_ACC,
        ST_MUL_SQR,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    rsa_me_pkg::word_t      modulus_reg;
    rsa_me_pkg::word_t      public_exponent_reg;
    rsa_me_pkg::word_t      private_exponent_reg;
    rsa_me_pkg::word_t      m_reg;
    rsa_me_pkg::word_t      exp_reg;
    rsa_me_pkg::word_t      base_reg;
    rsa_me_pkg::word_t      acc_reg;
    rsa_me_pkg::word_t      result_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   mm_start_reg;
    logic                   mm_start_next;
    rsa_me_pkg::word_t      mm_a_reg;
    rsa_me_pkg::word_t      mm_b_reg;
    rsa_me_pkg::word_t      mm_product;
    rsa_me_pkg::mm_status_t mm_status;
    rsa_me_pkg::word_t      one_mod;

    // 1 mod m: zero only for a modulus of one
    assign one_mod = {{(rsa_me_pkg::DATA_WIDTH-1){1'b0}}, (m_reg != rsa_me_pkg::word_t'(1))};

    // kick the multiplier on accept, on a step with exponent bits left, and
    // straight from the accumulate multiply into the square
    assign mm_start_next = ((state_reg == ST_IDLE) && in_valid && (modulus_reg != '0))
                        || ((state_reg == ST_STEP) && (exp_reg != '0))
                        || ((state_reg == ST_MUL_ACC) && mm_status.done);

    // finish always leaves a valid result; otherwise hold until taken
    assign out_valid_next = (state_reg == ST_FINISH) || (out_valid_reg && !out_ready);

    // shared modular multiplier
    rsa_me_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start_reg),
        .a       (mm_a_reg),
        .b       (mm_b_reg),
        .m       (m_reg),
        .product (mm_product),
        .status  (mm_status)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg          <= rsa_me_pkg::MODULUS_RST;
            public_exponent_reg  <= rsa_me_pkg::PUBLIC_EXPONENT_RST;
            private_exponent_reg <= rsa_me_pkg::PRIVATE_EXPONENT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rsa_me_pkg::CFG_MODULUS:          modulus_reg          <= cfg_data;
                rsa_me_pkg::CFG_PUBLIC_EXPONENT:  public_exponent_reg  <= cfg_data;
                rsa_me_pkg::CFG_PRIVATE_EXPONENT: private_exponent_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer: reduce operand, then multiply/square per exponent bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mm_start_reg  <= 1'b0;
            mm_a_reg      <= '0;
            mm_b_reg      <= '0;
            m_reg         <= '0;
            exp_reg       <= '0;
            base_reg      <= '0;
            acc_reg       <= '0;
            result_reg    <= '0;
        end
        else
        begin
            mm_start_reg  <= mm_start_next;
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        m_reg   <= modulus_reg;
                        exp_reg <= (command == rsa_me_pkg::CMD_DECRYPT) ?
                                   private_exponent_reg : public_exponent_reg;
                        if (modulus_reg == '0)
                        begin
                            // zero modulus gives zero
                            acc_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            // operand mod m as (1 mod m) * operand
                            mm_a_reg     <= (modulus_reg == rsa_me_pkg::word_t'(1)) ?
                                            '0 : rsa_me_pkg::word_t'(1);
                            mm_b_reg     <= operand_value;
                            state_reg    <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (mm_status.done)
                    begin
                        base_reg  <= mm_product;
                        acc_reg   <= one_mod;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    if (exp_reg == '0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (exp_reg[0])
                    begin
                        mm_a_reg     <= acc_reg;
                        mm_b_reg     <= base_reg;
                        state_reg    <= ST_MUL_ACC;
                    end
                    else
                    begin
                        mm_a_reg     <= base_reg;
                        mm_b_reg     <= base_reg;
                        state_reg    <= ST_MUL_SQR;
                    end
                end
                ST_MUL_ACC:
                begin
                    if (mm_status.done)
                    begin
                        acc_reg      <= mm_product;
                        mm_a_reg     <= base_reg;
                        mm_b_reg     <= base_reg;
                        state_reg    <= ST_MUL_SQR;
                    end
                end
                ST_MUL_SQR:
                begin
                    if (mm_status.done)
                    begin
                        base_reg  <= mm_product;
                        exp_reg   <= exp_reg >> 1;
                        state_reg <= ST_STEP;
                    end
                end
                ST_FINISH:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || out_ready)
                    begin
                        result_reg    <= acc_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign cfg_ready    = 1'b1;

    // a new transaction is only taken while the multiplier is quiet
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mm_status.busy)
        else $error("input accepted while multiplier busy");

    // the multiplier is never restarted mid-operation
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_start_reg |-> !mm_status.busy)
        else $error("multiplier started while busy");

    // done only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> $past(mm_status.busy))
        else $error("multiplier done without work");

    // a delivered result is always reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (modulus_reg != '0)) |-> (result_value < modulus_reg))
        else $error("result not below modulus");

endmodule
